>>> design/vmts_pkg.sv
// Shared constants, types and tables for the velocity modulated test signal synthesizer.
`default_nettype none
package vmts_pkg;

  localparam int COS_BITS = 10;
  localparam int NUM_W = 12 + COS_BITS;
  localparam int T_W = 23;
  localparam int CORDIC_STEPS = 16;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
    32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
    32'd166886, 32'd83443, 32'd41722, 32'd20861
  };

  typedef enum logic [2:0] {
    REG_AMP_X = 3'd0,
    REG_AMP_Y = 3'd1,
    REG_AMP_Z = 3'd2,
    REG_FREQ_X = 3'd3,
    REG_FREQ_Y = 3'd4,
    REG_FREQ_Z = 3'd5,
    REG_SPEED_LIMIT = 3'd6,
    REG_SAMPLE_RATE = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [7:0] amp;
    logic [11:0] freq;
    logic [7:0] limit;
    logic [11:0] rate;
  } lane_cfg_t;

  typedef struct packed {
    logic idle;
    logic done;
  } lane_stat_t;

endpackage
`default_nettype wire

>>> design/vmts_lane.sv
// One axis lane: velocity, phase step, index divide, sqrt, CORDIC cosine and product.
`default_nettype none
module vmts_lane (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire vmts_pkg::lane_cfg_t           cfg,
  input  wire logic                          start,
  input  wire logic                          pos_load,
  input  wire logic signed [23:0]            pos,
  input  wire logic                          ack,
  output vmts_pkg::lane_stat_t               stat,
  output logic signed [vmts_pkg::T_W-1:0]    t
);
  import vmts_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_MOD, S_IDX, S_COS, S_MUL1, S_MUL2, S_DONE} state_t;

  state_t state;
  logic signed [23:0] prev;
  logic signed [24:0] vel;
  logic [11:0] acc;
  logic [3:0] cnt;
  logic [12:0] rem_a, rem_f;
  logic [11:0] sh_a, sh_f;
  logic [COS_BITS:0] sh_n, q;
  logic signed [33:0] x, y, z;
  logic neg;
  logic [19:0] sq_rem;
  logic [16:0] sq_root;
  logic [33:0] sq_n;
  logic [4:0] sq_cnt;
  logic signed [24:0] prod1;
  logic signed [42:0] prod2;

  logic signed [25:0] lim, v_cl, u_full;
  logic [12:0] rt_a, rt_f, rt_n, rate13;
  logic [11:0] p;
  logic [12:0] step_sum;
  logic [11:0] acc_next;
  logic [NUM_W-1:0] num;
  logic [COS_BITS-1:0] idx;
  logic [31:0] angle, angle_t;
  logic signed [33:0] x_sh, y_sh, atan_v;
  logic [19:0] sq_rt, sq_trial;
  logic signed [17:0] x_r;
  logic signed [15:0] c_mag, c;
  logic signed [42:0] t_full;

  always_comb begin
    rate13 = {1'b0, cfg.rate};
    lim = 26'(signed'({1'b0, cfg.limit, 8'd0}));
    v_cl = 26'(vel);
    if (v_cl > lim) v_cl = lim;
    if (v_cl < -lim) v_cl = -lim;
    u_full = v_cl + lim;

    rt_a = {rem_a[11:0], sh_a[11]};
    rt_f = {rem_f[11:0], sh_f[11]};
    rt_n = {rem_a[11:0], sh_n[COS_BITS]};

    p = rem_a[11:0];
    step_sum = {1'b0, p} + rem_f;
    acc_next = (step_sum >= rate13) ? 12'(step_sum - rate13) : step_sum[11:0];
    num = {p, {COS_BITS{1'b0}}} + NUM_W'(cfg.rate >> 1);

    idx = q[COS_BITS-1:0];
    angle = {idx, {(32 - COS_BITS){1'b0}}};
    angle_t = angle + 32'h4000_0000;

    x_sh = x >>> cnt;
    y_sh = y >>> cnt;
    atan_v = 34'(signed'({1'b0, ATAN_TURN[cnt]}));

    sq_rt = {sq_rem[17:0], sq_n[33:32]};
    sq_trial = {1'b0, sq_root, 2'b01};

    x_r = 18'((x + 34'sd32768) >>> 16);
    if (x_r > 18'sd16384) c_mag = 16'sd16384;
    else if (x_r < -18'sd16384) c_mag = -16'sd16384;
    else c_mag = x_r[15:0];
    c = neg ? -c_mag : c_mag;

    t_full = (prod2 + 43'sd131072) >>> 18;
    t = t_full[T_W-1:0];
  end

  assign stat.idle = (state == S_IDLE);
  assign stat.done = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      prev <= '0;
      vel <= '0;
      acc <= '0;
      sq_cnt <= '0;
    end else begin
      if (sq_cnt != 5'd0) begin
        if (sq_rt >= sq_trial) begin
          sq_rem <= sq_rt - sq_trial;
          sq_root <= {sq_root[15:0], 1'b1};
        end else begin
          sq_rem <= sq_rt;
          sq_root <= {sq_root[15:0], 1'b0};
        end
        sq_n <= {sq_n[31:0], 2'b00};
        sq_cnt <= sq_cnt - 5'd1;
      end
      unique case (state)
        S_IDLE: begin
          if (pos_load) begin
            vel <= 25'(pos) - 25'(prev);
            prev <= pos;
          end else if (start) begin
            rem_a <= '0;
            rem_f <= '0;
            sh_a <= acc;
            sh_f <= cfg.freq;
            cnt <= 4'd11;
            sq_rem <= '0;
            sq_root <= '0;
            sq_n <= {1'b0, u_full[16:0], 16'd0};
            sq_cnt <= 5'd17;
            state <= S_MOD;
          end
        end
        S_MOD: begin
          rem_a <= (rt_a >= rate13) ? rt_a - rate13 : rt_a;
          rem_f <= (rt_f >= rate13) ? rt_f - rate13 : rt_f;
          sh_a <= {sh_a[10:0], 1'b0};
          sh_f <= {sh_f[10:0], 1'b0};
          cnt <= cnt - 4'd1;
          if (cnt == 4'd0) state <= S_IDX;
          if (cnt == 4'd0) cnt <= 4'(COS_BITS);
        end
        S_IDX: begin
          cnt <= cnt - 4'd1;
          if (cnt == 4'(COS_BITS) && sh_f[0] == 1'b0) begin
            acc <= acc_next;
            rem_a <= {2'b00, num[NUM_W-1:COS_BITS+1]};
            sh_n <= num[COS_BITS:0];
            q <= '0;
            sh_f <= 12'd1;
            cnt <= cnt;
          end else begin
            rem_a <= (rt_n >= rate13) ? rt_n - rate13 : rt_n;
            q <= {q[COS_BITS-1:0], rt_n >= rate13};
            sh_n <= {sh_n[COS_BITS-1:0], 1'b0};
            if (cnt == 4'd0) begin
              cnt <= 4'd0;
              state <= S_COS;
              sh_f <= 12'd0;
            end
          end
        end
        S_COS: begin
          if (sh_f[0] == 1'b0) begin
            neg <= angle_t[31];
            z <= 34'(signed'({angle[31] ^ angle_t[31], angle[30:0]}));
            x <= CORDIC_GAIN;
            y <= '0;
            cnt <= 4'd0;
            sh_f <= 12'd1;
          end else begin
            if (z >= 0) begin
              x <= x - y_sh;
              y <= y + x_sh;
              z <= z - atan_v;
            end else begin
              x <= x + y_sh;
              y <= y - x_sh;
              z <= z + atan_v;
            end
            cnt <= cnt + 4'd1;
            if (cnt == 4'(CORDIC_STEPS - 1)) state <= S_MUL1;
          end
        end
        S_MUL1: begin
          prod1 <= 25'(signed'({1'b0, cfg.amp})) * 25'(c);
          state <= S_MUL2;
        end
        S_MUL2: begin
          prod2 <= 43'(prod1) * 43'(signed'({1'b0, sq_root}));
          state <= S_DONE;
        end
        S_DONE: begin
          if (ack) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> design/vmts_merge.sv
// Merge stage: saturates the three axis values and their sum into the output register.
`default_nettype none
module vmts_merge (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          load,
  input  wire logic [31:0]                   index_in,
  input  wire logic signed [vmts_pkg::T_W-1:0] tx,
  input  wire logic signed [vmts_pkg::T_W-1:0] ty,
  input  wire logic signed [vmts_pkg::T_W-1:0] tz,
  input  wire logic                          out_stall,
  output logic                               ready,
  output logic                               out_valid,
  output logic [31:0]                        sample_index,
  output logic signed [15:0]                 chan_x,
  output logic signed [15:0]                 chan_y,
  output logic signed [15:0]                 chan_z,
  output logic signed [15:0]                 chan_sum
);
  import vmts_pkg::*;

  logic signed [T_W+1:0] sum;

  function automatic logic signed [15:0] sat16(input logic signed [T_W+1:0] v);
    logic signed [15:0] r;
    if (v > 25'sd32767) r = 16'sd32767;
    else if (v < -25'sd32768) r = -16'sd32768;
    else r = v[15:0];
    return r;
  endfunction

  assign sum = (T_W+2)'(tx) + (T_W+2)'(ty) + (T_W+2)'(tz);
  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
      sample_index <= index_in;
      chan_x <= sat16((T_W+2)'(tx));
      chan_y <= sat16((T_W+2)'(ty));
      chan_z <= sat16((T_W+2)'(tz));
      chan_sum <= sat16(sum);
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

>>> design/velocity_modulated_test_signal_synth_top.sv
// Top level of the velocity modulated four-channel test signal synthesizer.
// One word is taken at a time. A position word (action 0) updates the three
// velocities. A tick word (action 1) holds the input off while all three
// axes, in parallel lanes, run the phase and frequency modulo, the phase
// index divide, the CORDIC cosine and the products, and then hand the values
// to the output register when it is free; the square root runs alongside.
// The result then sits in the output register while the next word is taken.
`default_nettype none
module velocity_modulated_test_signal_synth_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [11:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               action,
  input  wire logic signed [23:0] pos_x,
  input  wire logic signed [23:0] pos_y,
  input  wire logic signed [23:0] pos_z,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [31:0]             sample_index,
  output logic signed [15:0]      chan_x,
  output logic signed [15:0]      chan_y,
  output logic signed [15:0]      chan_z,
  output logic signed [15:0]      chan_sum
);
  import vmts_pkg::*;

  logic [7:0] amp_x, amp_y, amp_z, speed_limit;
  logic [11:0] freq_x, freq_y, freq_z, sample_rate, rate_eff;
  logic [31:0] tick_count;
  lane_cfg_t cfg_x, cfg_y, cfg_z;
  lane_stat_t st_x, st_y, st_z;
  logic signed [T_W-1:0] tx, ty, tz;
  logic accept, start, pos_load, ack, merge_ready;

  assign rate_eff = (sample_rate == 12'd0) ? 12'd1 : sample_rate;
  assign cfg_x = '{amp: amp_x, freq: freq_x, limit: speed_limit, rate: rate_eff};
  assign cfg_y = '{amp: amp_y, freq: freq_y, limit: speed_limit, rate: rate_eff};
  assign cfg_z = '{amp: amp_z, freq: freq_z, limit: speed_limit, rate: rate_eff};

  assign in_stall = !(st_x.idle && st_y.idle && st_z.idle);
  assign accept = in_valid && !in_stall;
  assign start = accept && action;
  assign pos_load = accept && !action;
  assign ack = st_x.done && st_y.done && st_z.done && merge_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      amp_x <= 8'd32;
      amp_y <= 8'd32;
      amp_z <= 8'd32;
      freq_x <= 12'd10;
      freq_y <= 12'd20;
      freq_z <= 12'd30;
      speed_limit <= 8'd50;
      sample_rate <= 12'd1000;
      tick_count <= '0;
    end else begin
      if (ack) tick_count <= tick_count + 32'd1;
      if (cfg_we) begin
        unique case (reg_index_t'(cfg_index))
          REG_AMP_X: amp_x <= cfg_data[7:0];
          REG_AMP_Y: amp_y <= cfg_data[7:0];
          REG_AMP_Z: amp_z <= cfg_data[7:0];
          REG_FREQ_X: freq_x <= cfg_data;
          REG_FREQ_Y: freq_y <= cfg_data;
          REG_FREQ_Z: freq_z <= cfg_data;
          REG_SPEED_LIMIT: speed_limit <= cfg_data[7:0];
          REG_SAMPLE_RATE: sample_rate <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  vmts_lane u_lane_x (
    .clk(clk), .rst(rst), .cfg(cfg_x), .start(start), .pos_load(pos_load),
    .pos(pos_x), .ack(ack), .stat(st_x), .t(tx)
  );

  vmts_lane u_lane_y (
    .clk(clk), .rst(rst), .cfg(cfg_y), .start(start), .pos_load(pos_load),
    .pos(pos_y), .ack(ack), .stat(st_y), .t(ty)
  );

  vmts_lane u_lane_z (
    .clk(clk), .rst(rst), .cfg(cfg_z), .start(start), .pos_load(pos_load),
    .pos(pos_z), .ack(ack), .stat(st_z), .t(tz)
  );

  vmts_merge u_merge (
    .clk(clk), .rst(rst), .load(ack), .index_in(tick_count),
    .tx(tx), .ty(ty), .tz(tz), .out_stall(out_stall), .ready(merge_ready),
    .out_valid(out_valid), .sample_index(sample_index),
    .chan_x(chan_x), .chan_y(chan_y), .chan_z(chan_z), .chan_sum(chan_sum)
  );

endmodule
`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for the velocity modulated four-channel test signal synthesizer.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import vmts_pkg::*;

  localparam int RUN_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [31:0] idx;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [15:0] cz;
    logic signed [15:0] cs;
  } sample_t;

  function automatic longint unsigned int_root(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // angle in 2^-32 turn, result Q2.14
  function automatic longint cordic_cos(logic [31:0] ang);
    logic [31:0] quad;
    bit neg;
    longint x, y, z, nx;
    neg = 0;
    x = CORDIC_GAIN;
    y = 0;
    quad = ang + 32'h4000_0000;
    if (quad[31]) begin
      ang = ang - 32'h8000_0000;
      neg = 1;
    end
    z = longint'($signed(ang));
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= longint'(ATAN_TURN[i]);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += longint'(ATAN_TURN[i]);
      end
      x = nx;
    end
    x = (x + 32768) >>> 16;
    if (x > 16384) x = 16384;
    if (x < -16384) x = -16384;
    return neg ? -x : x;
  endfunction

  function automatic logic signed [15:0] sat16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return -16'sh8000;
    return v[15:0];
  endfunction

  class tone_scoreboard;
    bit [7:0] amp[3];
    bit [11:0] freq[3];
    bit [7:0] limit;
    bit [11:0] rate;
    logic signed [23:0] prev[3];
    logic signed [24:0] vel[3];
    bit [31:0] ticks;
    bit [11:0] phase[3];
    sample_t expected_q[$];
    int errors;

    function new();
      amp = '{32, 32, 32};
      freq = '{10, 20, 30};
      limit = 50;
      rate = 1000;
      prev = '{0, 0, 0};
      vel = '{0, 0, 0};
      phase = '{0, 0, 0};
      ticks = 0;
      errors = 0;
    endfunction

    function void set_reg(reg_index_t r, bit [11:0] d);
      case (r)
        REG_AMP_X: amp[0] = d[7:0];
        REG_AMP_Y: amp[1] = d[7:0];
        REG_AMP_Z: amp[2] = d[7:0];
        REG_FREQ_X: freq[0] = d;
        REG_FREQ_Y: freq[1] = d;
        REG_FREQ_Z: freq[2] = d;
        REG_SPEED_LIMIT: limit = d[7:0];
        REG_SAMPLE_RATE: rate = d;
        default: ;
      endcase
    endfunction

    function longint axis_tone(int k, int unsigned r);
      longint lim, v, c, rt;
      int unsigned p;
      longint unsigned ix;
      lim = longint'(limit) * 256;
      v = vel[k];
      if (v > lim) v = lim;
      if (v < -lim) v = -lim;
      rt = longint'(int_root(longint'(v + lim) << 16));
      p = phase[k] % r;
      ix = ((longint'(p) << COS_BITS) + r / 2) / r;
      ix &= (64'd1 << COS_BITS) - 1;
      c = cordic_cos(32'(ix << (32 - COS_BITS)));
      phase[k] = 12'((p + freq[k] % r) % r);
      return (longint'(amp[k]) * c * rt + (longint'(1) << 17)) >>> 18;
    endfunction

    function void note_word(bit act, logic signed [23:0] x, logic signed [23:0] y,
                            logic signed [23:0] z);
      logic signed [23:0] p[3];
      longint t[3];
      int unsigned r;
      sample_t s;
      p = '{x, y, z};
      if (!act) begin
        for (int k = 0; k < 3; k++) begin
          vel[k] = p[k] - prev[k];
          prev[k] = p[k];
        end
        return;
      end
      r = (rate == 0) ? 1 : rate;
      for (int k = 0; k < 3; k++) t[k] = axis_tone(k, r);
      s.idx = ticks;
      s.cx = sat16(t[0]);
      s.cy = sat16(t[1]);
      s.cz = sat16(t[2]);
      s.cs = sat16(t[0] + t[1] + t[2]);
      expected_q.push_back(s);
      ticks++;
    endfunction

    function void cmp(string name, longint e, longint a);
      if (e != a) begin
        errors++;
        $display("%0t %s expected %0d got %0d", $time, name, e, a);
      end
    endfunction

    function void check_sample(sample_t s);
      sample_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t unexpected sample %0d got %0d", $time, -1, s.idx);
        return;
      end
      e = expected_q.pop_front();
      cmp("sample_index", e.idx, s.idx);
      cmp("chan_x", e.cx, s.cx);
      cmp("chan_y", e.cy, s.cy);
      cmp("chan_z", e.cz, s.cz);
      cmp("chan_sum", e.cs, s.cs);
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [11:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic action = 0;
  logic signed [23:0] pos_x = '0;
  logic signed [23:0] pos_y = '0;
  logic signed [23:0] pos_z = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [31:0] sample_index;
  logic signed [15:0] chan_x, chan_y, chan_z, chan_sum;

  tone_scoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_go = 0;
  int hold_left = 0;
  int cycle_count = 0;
  logic signed [23:0] last_pos[3] = '{0, 0, 0};

  velocity_modulated_test_signal_synth_top DUT (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial forever begin
    @(posedge clk);
    if (hold_go) begin
      hold_go = 0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial forever begin
    @(negedge clk);
    if (!rst && out_valid && !out_stall)
      sb.check_sample('{sample_index, chan_x, chan_y, chan_z, chan_sum});
  end

  task automatic send_word(bit act, logic signed [23:0] x, logic signed [23:0] y,
                           logic signed [23:0] z);
    bit ok;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    action <= act;
    pos_x <= x;
    pos_y <= y;
    pos_z <= z;
    forever begin
      @(negedge clk);
      ok = !in_stall;
      @(posedge clk);
      if (ok) break;
    end
    sb.note_word(act, x, y, z);
    if (!act) last_pos = '{x, y, z};
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(bit [11:0] vals[8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      cfg_we <= 0;
      @(posedge clk);
      sb.set_reg(reg_index_t'(i), vals[i]);
    end
  endtask

  function automatic bit [11:0] pick(int lo, int hi);
    int r;
    r = $urandom_range(99);
    if (r < 15) return 12'(lo);
    if (r < 30) return 12'(hi);
    return 12'($urandom_range(hi, lo));
  endfunction

  function automatic logic signed [23:0] near_pos(logic signed [23:0] p);
    int span;
    span = int'(sb.limit) * 256 + 300;
    if ($urandom_range(99) < 25) return 24'($urandom);
    return p + 24'($urandom_range(2 * span, 0) - span);
  endfunction

  task automatic random_word();
    if ($urandom_range(1))
      send_word(1, 24'($urandom), 24'($urandom), 24'($urandom));
    else
      send_word(0, near_pos(last_pos[0]), near_pos(last_pos[1]), near_pos(last_pos[2]));
  endtask

  localparam logic signed [23:0] PMAX = 24'sh7fffff;
  localparam logic signed [23:0] PMIN = -24'sh800000;

  initial begin
    bit [11:0] cfg[8];
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_word(1, 0, 0, 0);
    send_word(0, PMAX, 0, PMIN);
    send_word(1, 0, 0, 0);
    send_word(0, PMIN, PMAX, PMAX);
    send_word(1, 0, 0, 0);
    send_word(0, 256, -256, 0);
    send_word(1, 0, 0, 0);
    send_word(1, 0, 0, 0);
    drain();

    // full scale: saturating channels, freq equal to and just below rate
    cfg = '{255, 255, 255, 4095, 4095, 4000, 255, 4095};
    write_regs(cfg);
    send_word(0, PMAX, PMAX, PMAX);
    send_word(1, 0, 0, 0);
    send_word(0, PMAX, PMAX, PMAX);
    send_word(1, 0, 0, 0);
    send_word(1, 0, 0, 0);
    drain();
    // rate shrinks below stored phase; zero speed limit
    cfg = '{255, 0, 128, 4095, 0, 7, 0, 3};
    write_regs(cfg);
    send_word(1, 0, 0, 0);
    send_word(0, 1000, -1000, 5);
    send_word(1, 0, 0, 0);
    drain();
    // zero sample rate
    cfg = '{200, 100, 50, 1, 2, 3, 255, 0};
    write_regs(cfg);
    send_word(1, 0, 0, 0);
    send_word(0, 0, 0, 0);
    send_word(1, 0, 0, 0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      cfg = '{pick(0, 255), pick(0, 255), pick(0, 255), pick(0, 4095), pick(0, 4095),
              pick(0, 4095), pick(0, 255), pick(0, 4095)};
      if (ph == 1) cfg[7] = 12'd1;
      write_regs(cfg);
      case (ph % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 48; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 48; end
        default: begin idle_pct = 21; stall_pct = 21; end
      endcase
      if (ph == 4) hold_go = 1;
      for (int n = 0; n < 66; n++) random_word();
      drain();
    end

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
